// ===== rtl/tdm_pkg.sv =====
`default_nettype none

package tdm_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int MAX_STATES_DEF  = 64;

    localparam int STATE_W = 7;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [STATE_W-1:0] t_state;

    typedef enum logic [1:0] {
        FUNC_ALPHA  = 2'd0,
        FUNC_TRANS  = 2'd1,
        FUNC_ACCEPT = 2'd2,
        FUNC_FEED   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_SYM_CNT   = 2'd0,
        REG_STATE_CNT = 2'd1,
        REG_START     = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_STEP,
        FSM_FLAG
    } t_fsm;

    typedef struct packed {
        t_func      func;
        t_state     row_state;
        logic [3:0] symbol_slot;
        logic [7:0] char_code;
        t_state     target_state;
        logic       accept_bit;
        logic       last;
    } t_item;

    typedef struct packed {
        logic   accepted;
        t_state final_state;
        logic   unknown_symbol;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/tdm_ram.sv =====
`default_nettype none

module tdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/table_driven_dfa_matcher.sv =====
`default_nettype none

// Programmable DFA string acceptor.
// Items enter on i_item when start is high and busy is low. Load items
// (alphabet entry, transition entry, accepting flag) are written at the
// accepting edge; busy stays low after them. A feed item carries one
// character: the alphabet is searched at the accepting edge and the
// transition memory is read there, so the string state takes the next
// state in the step state. A feed with last then reads the accepting-flag
// memory: the result is shown on o_result with o_strobe high in the flag
// state after the step state. The registered read of the transition
// memory, on which the next state depends, keeps busy high until the feed
// is through. The receiver cannot hold results off: each result is valid
// for exactly one cycle. Configuration goes through the APB port (symbol
// count at 0x0, state count at 0x4, start state at 0x8). The user must
// configure only while idle; the block does not enforce it.
// Synchronous reset clears the configuration to 1/1/1, the string
// state and all accepting flags; the alphabet and transition stores
// hold whatever they held and must be loaded before use.
module table_driven_dfa_matcher #(
    parameter int MAX_SYMBOLS = tdm_pkg::MAX_SYMBOLS_DEF,
    parameter int MAX_STATES  = tdm_pkg::MAX_STATES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire tdm_pkg::t_item                i_item,
    // result channel
    output logic                               o_strobe,
    output tdm_pkg::t_result                   o_result,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tdm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tdm_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tdm_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import tdm_pkg::*;

    // Rows reachable through a 7-bit state number.
    localparam int AF_DEPTH = (MAX_STATES < 127) ? MAX_STATES : 127;
    localparam int AF_W     = $clog2(AF_DEPTH);
    localparam int SYM_W    = $clog2(MAX_SYMBOLS);
    localparam int TR_DEPTH = AF_DEPTH * MAX_SYMBOLS;
    localparam int TA_W     = $clog2(TR_DEPTH);

    // Configuration registers
    logic [4:0] r_sym_cnt;
    t_state     r_state_cnt;
    t_state     r_start;

    // String state
    t_fsm   r_fsm, n_fsm;
    t_state r_state;
    logic   r_mid;
    logic   r_unk;
    logic   r_found;
    logic   r_last;

    logic [7:0]          r_alpha [MAX_SYMBOLS];
    logic [AF_DEPTH-1:0] r_acc_vld;

    logic            accept_item;
    logic            row_ok;
    logic            slot_ok;
    logic            hit;
    logic [SYM_W-1:0] hit_idx;
    t_state          cur_state;
    t_state          stp_next;
    logic [TA_W-1:0] tr_waddr;
    logic [TA_W-1:0] tr_raddr;
    t_state          tr_q;
    logic [AF_W-1:0] acc_waddr;
    logic [AF_W-1:0] acc_raddr;
    logic [AF_W-1:0] acc_idx;
    logic            acc_q;
    logic            cfg_wr;

    // Dead state for zero or anything beyond the active state count.
    function automatic t_state clamp_st(input t_state s, input t_state lim);
        clamp_st = (s == '0 || s > lim || 32'(s) > MAX_STATES) ? '0 : s;
    endfunction

    assign accept_item = start && !busy;
    assign row_ok  = (i_item.row_state != '0) && (32'(i_item.row_state) <= MAX_STATES);
    assign slot_ok = 32'(i_item.symbol_slot) < MAX_SYMBOLS;

    // Alphabet search: lowest active entry that matches wins.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
            if (32'(k) < 32'(r_sym_cnt) && r_alpha[k] == i_item.char_code) begin
                hit     = 1'b1;
                hit_idx = SYM_W'(k);
            end
        end
    end

    // A new string begins at the configured start state.
    assign cur_state = r_mid ? r_state : clamp_st(r_start, r_state_cnt);

    assign tr_raddr  = TA_W'(32'(cur_state - 7'd1) * MAX_SYMBOLS + 32'(hit_idx));
    assign tr_waddr  = TA_W'(32'(i_item.row_state - 7'd1) * MAX_SYMBOLS
                             + 32'(i_item.symbol_slot));

    // Next state once the table entry is back; unknown or dead stays dead.
    assign stp_next  = (!r_found || r_state == '0) ? '0 : clamp_st(tr_q, r_state_cnt);

    assign acc_waddr = AF_W'(i_item.row_state - 7'd1);
    assign acc_raddr = AF_W'(stp_next - 7'd1);
    assign acc_idx   = AF_W'(r_state - 7'd1);

    tdm_ram #(
        .WIDTH (STATE_W),
        .DEPTH (TR_DEPTH)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (accept_item && i_item.func == FUNC_TRANS && row_ok && slot_ok),
        .i_waddr (tr_waddr),
        .i_wdata (i_item.target_state),
        .i_raddr (tr_raddr),
        .o_rdata (tr_q)
    );

    tdm_ram #(
        .WIDTH (1),
        .DEPTH (AF_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (accept_item && i_item.func == FUNC_ACCEPT && row_ok),
        .i_waddr (acc_waddr),
        .i_wdata (i_item.accept_bit),
        .i_raddr (acc_raddr),
        .o_rdata (acc_q)
    );

    // Alphabet entries: written directly, no reset.
    always_ff @(posedge i_clk) begin
        if (accept_item && i_item.func == FUNC_ALPHA && slot_ok) begin
            r_alpha[SYM_W'(i_item.symbol_slot)] <= i_item.char_code;
        end
    end

    // Accepting flags read as cleared until written after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (accept_item && i_item.func == FUNC_ACCEPT && row_ok) begin
            r_acc_vld[acc_waddr] <= 1'b1;
        end
    end

    // Configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_cnt   <= 5'd1;
            r_state_cnt <= 7'd1;
            r_start     <= 7'd1;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[3:2]))
                REG_SYM_CNT:   r_sym_cnt   <= pwdata[4:0];
                REG_STATE_CNT: r_state_cnt <= pwdata[STATE_W-1:0];
                REG_START:     r_start     <= pwdata[STATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_SYM_CNT:   prdata = PDATA_W'(r_sym_cnt);
            REG_STATE_CNT: prdata = PDATA_W'(r_state_cnt);
            REG_START:     prdata = PDATA_W'(r_start);
            default:       prdata = '0;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= FSM_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            FSM_IDLE: begin
                if (accept_item && i_item.func == FUNC_FEED) begin
                    n_fsm = FSM_STEP;
                end
            end
            FSM_STEP: n_fsm = r_last ? FSM_FLAG : FSM_IDLE;
            FSM_FLAG: n_fsm = FSM_IDLE;
            default:  n_fsm = FSM_IDLE;
        endcase
    end

    assign busy = (r_fsm != FSM_IDLE);

    // String state: take the character, advance, drop at the end of the string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_mid   <= 1'b0;
            r_unk   <= 1'b0;
            r_found <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_fsm)
                FSM_IDLE: begin
                    if (accept_item && i_item.func == FUNC_FEED) begin
                        r_state <= cur_state;
                        r_mid   <= 1'b1;
                        r_unk   <= (r_mid && r_unk) || !hit;
                        r_found <= hit;
                        r_last  <= i_item.last;
                    end
                end
                FSM_STEP: begin
                    r_state <= stp_next;
                end
                FSM_FLAG: begin
                    r_state <= '0;
                    r_mid   <= 1'b0;
                    r_unk   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Result: shown for the one cycle spent in the flag state.
    assign o_strobe                = (r_fsm == FSM_FLAG);
    assign o_result.accepted       = (r_state != '0) && r_acc_vld[acc_idx] && acc_q;
    assign o_result.final_state    = r_state;
    assign o_result.unknown_symbol = r_unk;

    // Checks
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result shown while new items could be taken");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_feed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func == FUNC_FEED) |=> busy)
        else $error("feed item did not occupy the block");

    a_unknown_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == FSM_STEP && !r_found) |=> (r_state == '0 && r_unk))
        else $error("unknown character did not reach the dead state");

endmodule

`default_nettype wire
